>>> src/jac_pkg.sv
// Package for the joystick axis conditioner: widths, codes, per-axis entry layout
// and the structs passed between the RAM, divider and top level. No dependencies.
`default_nettype none

package jac_pkg;

    localparam int AXES             = 6;
    localparam int FULL_SCALE       = 350;
    localparam int MAX_ZERO_SAMPLES = 65535;
    localparam int ADC_TOP          = 1023;

    localparam int FUNC_W      = 3;
    localparam int AXIS_W      = 3;
    localparam int SAMPLE_W    = 10;
    localparam int BOUND_W     = 11;
    localparam int COND_W      = 16;
    localparam int DEAD_BAND_W = 7;
    localparam int SUM_W       = 26;
    localparam int COUNT_W     = 16;
    localparam int ADDR_W      = (AXES > 1) ? $clog2(AXES) : 1;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 10;

    localparam int DEAD_BAND_RESET        = 3;
    localparam int CENTER_LOW_WARN_RESET  = 0;
    localparam int CENTER_HIGH_WARN_RESET = 1023;
    localparam int SPREAD_WARN_RESET      = 10;
    localparam int CENTER_RESET           = 512;
    localparam int BOUND_RESET            = 512;

    localparam int DIVIDEND_W         = SUM_W;
    localparam int DIVISOR_W          = COUNT_W;
    localparam int DIV_BITS_PER_CYCLE = 2;
    localparam int DIV_STEPS          = DIVIDEND_W / DIV_BITS_PER_CYCLE;
    localparam int DIV_CNT_W          = $clog2(DIV_STEPS + 1);

    typedef enum logic [FUNC_W-1:0] {
        FN_RUN          = 3'd0,
        FN_ZERO_SAMPLE  = 3'd1,
        FN_ZERO_FINISH  = 3'd2,
        FN_RANGE_START  = 3'd3,
        FN_RANGE_SAMPLE = 3'd4,
        FN_SET_BOUND    = 3'd5
    } func_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DEAD_BAND        = 3'd0,
        CFG_INVERT_MASK      = 3'd1,
        CFG_CENTER_LOW_WARN  = 3'd2,
        CFG_CENTER_HIGH_WARN = 3'd3,
        CFG_SPREAD_WARN      = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0]       center;
        logic signed [BOUND_W-1:0] low_bound;
        logic signed [BOUND_W-1:0] high_bound;
        logic [SUM_W-1:0]          zero_sum;
        logic [COUNT_W-1:0]        zero_count;
        logic [SAMPLE_W-1:0]       zero_low;
        logic [SAMPLE_W-1:0]       zero_high;
        logic [SAMPLE_W-1:0]       last_spread;
    } entry_t;

    localparam entry_t ENTRY_RESET = '{
        center:      SAMPLE_W'(CENTER_RESET),
        low_bound:   -BOUND_W'(BOUND_RESET),
        high_bound:  BOUND_W'(BOUND_RESET),
        zero_sum:    '0,
        zero_count:  '0,
        zero_low:    SAMPLE_W'(ADC_TOP),
        zero_high:   '0,
        last_spread: '0
    };

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        entry_t            data;
    } ram_wr_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

>>> src/jac_if.sv
// Channel interfaces of the joystick axis conditioner: input item and result item.
// Depends on jac_pkg for field widths.
`default_nettype none

interface jac_in_if;
    logic                               valid;
    logic                               ready;
    logic [jac_pkg::FUNC_W-1:0]         func;
    logic [jac_pkg::AXIS_W-1:0]         axis;
    logic [jac_pkg::SAMPLE_W-1:0]       sample;
    logic signed [jac_pkg::BOUND_W-1:0] bound_value;
    logic                               bound_is_max;

    modport source (output valid, func, axis, sample, bound_value, bound_is_max,
                    input ready);
    modport sink   (input valid, func, axis, sample, bound_value, bound_is_max,
                    output ready);
endinterface

interface jac_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [jac_pkg::COND_W-1:0] conditioned;
    logic [jac_pkg::SAMPLE_W-1:0]      center;
    logic [jac_pkg::SAMPLE_W-1:0]      spread;
    logic                              warn;

    modport source (output valid, conditioned, center, spread, warn, input ready);
    modport sink   (input valid, conditioned, center, spread, warn, output ready);
endinterface

`default_nettype wire

>>> src/jac_axis_ram.sv
// Per-axis state memory: one entry per axis, registered read.
// Entries never written read as their reset value. Depends on jac_pkg.
`default_nettype none

module jac_axis_ram (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rd_en,
    input  logic [jac_pkg::ADDR_W-1:0] rd_addr,
    output jac_pkg::entry_t            rd_data,
    input  jac_pkg::ram_wr_t           wr
);
    import jac_pkg::*;

    entry_t          mem [AXES];
    logic [AXES-1:0] valid_reg;
    entry_t          rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : ENTRY_RESET;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> src/jac_divider.sv
// Shared unsigned restoring divider, two quotient bits per cycle.
// Serves the zeroing mean and the run mapping. Depends on jac_pkg.
`default_nettype none

module jac_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  jac_pkg::div_req_t req,
    output jac_pkg::div_rsp_t rsp
);
    import jac_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  divisor_reg;
    logic [DIVISOR_W-1:0]  rem_next;
    logic [DIVIDEND_W-1:0] quo_next;
    logic [DIVISOR_W:0]    trial;

    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        trial    = '0;
        for (int i = 0; i < DIV_BITS_PER_CYCLE; i++)
        begin
            trial    = {rem_next, quo_next[DIVIDEND_W-1]};
            quo_next = {quo_next[DIVIDEND_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor_reg})
            begin
                rem_next    = DIVISOR_W'(trial - {1'b0, divisor_reg});
                quo_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial[DIVISOR_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg     <= '0;
            quo_reg     <= req.dividend;
            divisor_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

>>> src/joystick_axis_conditioner.sv
// Joystick axis conditioner top level: sequencer, configuration registers, output stage.
// Depends on jac_pkg, jac_if, jac_axis_ram and jac_divider.
//
// Usage:
//   item   : input transactions (function code, axis, sample, bound), valid/ready.
//   result : one result transaction per item, valid/ready, held in an output register.
//   cfg_*  : write port for the five registers; write only while the block is idle.
// One item is in work at a time. The axis entry is read from the state RAM, modified
// and written back. A zeroing finish with samples and a run item that needs mapping
// use the shared divider, which yields two quotient bits per cycle. A new item can be
// accepted in the cycle after the result moves into the output register.
// An item with an axis out of range returns all zeros and touches no state.
// Reset loads the register defaults and marks every axis entry as reset; no clearing
// pass is needed. A stalled receiver holds the result; one more item is then
// processed and waits until the output register frees.
`default_nettype none

module joystick_axis_conditioner (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [jac_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [jac_pkg::CFG_DATA_W-1:0]  cfg_data,
    jac_in_if.sink                          item,
    jac_out_if.source                       result
);
    import jac_pkg::*;

    localparam int MAP_W = BOUND_W + 2;
    localparam int MAG_W = MAP_W - 1;
    localparam int V_W   = DIVIDEND_W + 2;
    localparam logic signed [V_W-1:0] V_MAX = V_W'(2 ** (COND_W - 1) - 1);
    localparam logic signed [V_W-1:0] V_MIN = -V_W'(2 ** (COND_W - 1));

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_EXEC = 6'b000010,
        ST_MUL  = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_FIN  = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [DEAD_BAND_W-1:0] dead_band_reg;
    logic [AXES-1:0]        invert_mask_reg;
    logic [SAMPLE_W-1:0]    center_low_warn_reg;
    logic [SAMPLE_W-1:0]    center_high_warn_reg;
    logic [SAMPLE_W-1:0]    spread_warn_reg;

    logic [FUNC_W-1:0]         func_reg;
    logic [ADDR_W-1:0]         axis_reg;
    logic [SAMPLE_W-1:0]       raw_reg;
    logic signed [BOUND_W-1:0] bound_reg;
    logic                      is_max_reg;

    logic [MAG_W-1:0] diff_mag_reg;
    logic [MAG_W-1:0] span_mag_reg;
    logic             q_neg_reg;
    logic             neg_branch_reg;

    logic signed [COND_W-1:0] res_cond_reg;
    logic [SAMPLE_W-1:0]      res_center_reg;
    logic [SAMPLE_W-1:0]      res_spread_reg;
    logic                     res_warn_reg;

    logic                     out_valid_reg;
    logic signed [COND_W-1:0] out_cond_reg;
    logic [SAMPLE_W-1:0]      out_center_reg;
    logic [SAMPLE_W-1:0]      out_spread_reg;
    logic                     out_warn_reg;

    logic     accept;
    logic     axis_ok;
    logic     out_load;
    logic     ram_rd_en;
    entry_t   ent;
    ram_wr_t  ram_wr;
    div_req_t div_req;
    div_rsp_t div_rsp;

    logic signed [SAMPLE_W+1:0] c_old_w;
    logic signed [BOUND_W-1:0]  c_old;
    logic signed [MAP_W-1:0]    c_m;
    logic signed [MAP_W-1:0]    d_m;
    logic signed [MAP_W-1:0]    mag_m;
    logic signed [MAP_W-1:0]    low_m;
    logic signed [MAP_W-1:0]    high_m;
    logic signed [MAP_W-1:0]    diff_m;
    logic signed [MAP_W-1:0]    span_m;
    logic signed [MAP_W-1:0]    diff_abs;
    logic signed [MAP_W-1:0]    span_abs;
    logic                       dead_zone;
    logic                       pos_branch;

    entry_t                   exec_entry;
    logic signed [COND_W-1:0] exec_cond;
    logic                     exec_warn;
    logic                     exec_write;
    logic                     exec_to_div;
    logic                     exec_to_mul;

    logic                       fin_is_finish;
    logic [SAMPLE_W-1:0]        fin_center;
    logic [SAMPLE_W-1:0]        fin_spread;
    logic signed [SAMPLE_W+1:0] fin_c_w;
    logic signed [BOUND_W-1:0]  fin_c;
    logic                       fin_warn;
    entry_t                     fin_entry;
    logic signed [V_W-1:0]      q_mag;
    logic signed [V_W-1:0]      q_signed;
    logic signed [V_W-1:0]      map_v;
    logic signed [COND_W-1:0]   run_cond;
    logic signed [COND_W-1:0]   fin_cond;

    function automatic logic warn_test(
        input logic [SAMPLE_W-1:0] spread_val,
        input logic [SAMPLE_W-1:0] center_val,
        input logic [SAMPLE_W-1:0] spread_lim,
        input logic [SAMPLE_W-1:0] center_lo,
        input logic [SAMPLE_W-1:0] center_hi
    );
        return (spread_val > spread_lim) || (center_val < center_lo) ||
               (center_val > center_hi);
    endfunction

    jac_axis_ram u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (ram_rd_en),
        .rd_addr (item.axis[ADDR_W-1:0]),
        .rd_data (ent),
        .wr      (ram_wr)
    );

    jac_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign item.ready = (state_reg == ST_IDLE);
    assign accept     = item.valid && (state_reg == ST_IDLE);
    assign axis_ok    = ({1'b0, item.axis} < (AXIS_W + 1)'(AXES));
    assign ram_rd_en  = accept && axis_ok;
    assign out_load   = (state_reg == ST_OUT) && (!out_valid_reg || result.ready);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_band_reg        <= DEAD_BAND_W'(DEAD_BAND_RESET);
            invert_mask_reg      <= '0;
            center_low_warn_reg  <= SAMPLE_W'(CENTER_LOW_WARN_RESET);
            center_high_warn_reg <= SAMPLE_W'(CENTER_HIGH_WARN_RESET);
            spread_warn_reg      <= SAMPLE_W'(SPREAD_WARN_RESET);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_DEAD_BAND:        dead_band_reg        <= cfg_data[DEAD_BAND_W-1:0];
                CFG_INVERT_MASK:      invert_mask_reg      <= cfg_data[AXES-1:0];
                CFG_CENTER_LOW_WARN:  center_low_warn_reg  <= cfg_data[SAMPLE_W-1:0];
                CFG_CENTER_HIGH_WARN: center_high_warn_reg <= cfg_data[SAMPLE_W-1:0];
                CFG_SPREAD_WARN:      spread_warn_reg      <= cfg_data[SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    // centered value and run mapping operands
    always_comb
    begin
        c_old_w    = $signed({2'b00, raw_reg}) - $signed({2'b00, ent.center});
        c_old      = c_old_w[BOUND_W-1:0];
        c_m        = MAP_W'(c_old);
        d_m        = $signed(MAP_W'(dead_band_reg));
        low_m      = MAP_W'(ent.low_bound);
        high_m     = MAP_W'(ent.high_bound);
        mag_m      = c_m[MAP_W-1] ? -c_m : c_m;
        dead_zone  = (mag_m < d_m);
        pos_branch = (c_m >= d_m);
        diff_m     = pos_branch ? (c_m - d_m) : (c_m - low_m);
        span_m     = pos_branch ? (high_m - d_m) : (-d_m - low_m);
        diff_abs   = diff_m[MAP_W-1] ? -diff_m : diff_m;
        span_abs   = span_m[MAP_W-1] ? -span_m : span_m;
    end

    // first pass over the entry
    always_comb
    begin
        exec_entry  = ent;
        exec_cond   = COND_W'(c_old);
        exec_warn   = 1'b0;
        exec_write  = 1'b0;
        exec_to_div = 1'b0;
        exec_to_mul = 1'b0;
        unique case (func_reg)
            FN_RUN:
            begin
                exec_cond   = '0;
                exec_to_mul = !dead_zone && (span_m != '0);
            end
            FN_ZERO_SAMPLE:
            begin
                exec_write = 1'b1;
                if (ent.zero_count < COUNT_W'(MAX_ZERO_SAMPLES))
                begin
                    exec_entry.zero_sum   = ent.zero_sum + SUM_W'(raw_reg);
                    exec_entry.zero_count = ent.zero_count + 1'b1;
                    if (raw_reg < ent.zero_low)
                    begin
                        exec_entry.zero_low = raw_reg;
                    end
                    if (raw_reg > ent.zero_high)
                    begin
                        exec_entry.zero_high = raw_reg;
                    end
                end
            end
            FN_ZERO_FINISH:
            begin
                if (ent.zero_count != '0)
                begin
                    exec_to_div = 1'b1;
                end
                else
                begin
                    exec_write             = 1'b1;
                    exec_entry.last_spread = '0;
                    exec_entry.zero_sum    = ENTRY_RESET.zero_sum;
                    exec_entry.zero_count  = ENTRY_RESET.zero_count;
                    exec_entry.zero_low    = ENTRY_RESET.zero_low;
                    exec_entry.zero_high   = ENTRY_RESET.zero_high;
                    exec_warn = warn_test('0, ent.center, spread_warn_reg,
                                          center_low_warn_reg, center_high_warn_reg);
                end
            end
            FN_RANGE_START:
            begin
                exec_write            = 1'b1;
                exec_entry.low_bound  = BOUND_W'(ADC_TOP);
                exec_entry.high_bound = '0;
            end
            FN_RANGE_SAMPLE:
            begin
                exec_write = 1'b1;
                if (c_old < ent.low_bound)
                begin
                    exec_entry.low_bound = c_old;
                end
                if (c_old > ent.high_bound)
                begin
                    exec_entry.high_bound = c_old;
                end
            end
            FN_SET_BOUND:
            begin
                exec_write = 1'b1;
                if (is_max_reg)
                begin
                    exec_entry.high_bound = bound_reg;
                end
                else
                begin
                    exec_entry.low_bound = bound_reg;
                end
            end
            default: ;
        endcase
    end

    // completion after a division
    always_comb
    begin
        fin_is_finish = (func_reg == FN_ZERO_FINISH);
        fin_center    = div_rsp.quotient[SAMPLE_W-1:0];
        fin_spread    = ent.zero_high - ent.zero_low;
        fin_c_w       = $signed({2'b00, raw_reg}) - $signed({2'b00, fin_center});
        fin_c         = fin_c_w[BOUND_W-1:0];
        fin_warn      = warn_test(fin_spread, fin_center, spread_warn_reg,
                                  center_low_warn_reg, center_high_warn_reg);
        fin_entry             = ent;
        fin_entry.center      = fin_center;
        fin_entry.last_spread = fin_spread;
        fin_entry.zero_sum    = ENTRY_RESET.zero_sum;
        fin_entry.zero_count  = ENTRY_RESET.zero_count;
        fin_entry.zero_low    = ENTRY_RESET.zero_low;
        fin_entry.zero_high   = ENTRY_RESET.zero_high;

        q_mag    = $signed(V_W'(div_rsp.quotient));
        q_signed = q_neg_reg ? -q_mag : q_mag;
        map_v    = q_signed - (neg_branch_reg ? V_W'(FULL_SCALE) : V_W'(0));
        if (map_v > V_MAX)
        begin
            run_cond = V_MAX[COND_W-1:0];
        end
        else if (map_v < V_MIN)
        begin
            run_cond = V_MIN[COND_W-1:0];
        end
        else
        begin
            run_cond = map_v[COND_W-1:0];
        end
        fin_cond = fin_is_finish ? COND_W'(fin_c) : run_cond;
    end

    always_comb
    begin
        ram_wr.en   = ((state_reg == ST_EXEC) && exec_write) ||
                      ((state_reg == ST_FIN) && fin_is_finish);
        ram_wr.addr = axis_reg;
        ram_wr.data = (state_reg == ST_FIN) ? fin_entry : exec_entry;

        div_req.start    = ((state_reg == ST_EXEC) && exec_to_div) || (state_reg == ST_MUL);
        div_req.dividend = (state_reg == ST_MUL) ?
                           DIVIDEND_W'(diff_mag_reg) * DIVIDEND_W'(FULL_SCALE) :
                           ent.zero_sum;
        div_req.divisor  = (state_reg == ST_MUL) ? DIVISOR_W'(span_mag_reg) :
                           ent.zero_count;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    state_next = axis_ok ? ST_EXEC : ST_OUT;
                end
            end
            ST_EXEC:
            begin
                if (exec_to_mul)
                begin
                    state_next = ST_MUL;
                end
                else if (exec_to_div)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_MUL:  state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:  state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    func_reg       <= item.func;
                    axis_reg       <= item.axis[ADDR_W-1:0];
                    raw_reg        <= invert_mask_reg[item.axis[ADDR_W-1:0]] ?
                                      SAMPLE_W'(ADC_TOP) - item.sample : item.sample;
                    bound_reg      <= item.bound_value;
                    is_max_reg     <= item.bound_is_max;
                    res_cond_reg   <= '0;
                    res_center_reg <= '0;
                    res_spread_reg <= '0;
                    res_warn_reg   <= 1'b0;
                end
            end
            ST_EXEC:
            begin
                res_cond_reg   <= exec_cond;
                res_center_reg <= exec_entry.center;
                res_spread_reg <= exec_entry.last_spread;
                res_warn_reg   <= exec_warn;
                diff_mag_reg   <= diff_abs[MAG_W-1:0];
                span_mag_reg   <= span_abs[MAG_W-1:0];
                q_neg_reg      <= diff_m[MAP_W-1] ^ span_m[MAP_W-1];
                neg_branch_reg <= !pos_branch;
            end
            ST_FIN:
            begin
                res_cond_reg   <= fin_cond;
                res_center_reg <= fin_is_finish ? fin_center : ent.center;
                res_spread_reg <= fin_is_finish ? fin_spread : ent.last_spread;
                res_warn_reg   <= fin_is_finish && fin_warn;
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    out_cond_reg   <= res_cond_reg;
                    out_center_reg <= res_center_reg;
                    out_spread_reg <= res_spread_reg;
                    out_warn_reg   <= res_warn_reg;
                end
            end
            default: ;
        endcase
    end

    assign result.valid       = out_valid_reg;
    assign result.conditioned = out_cond_reg;
    assign result.center      = out_center_reg;
    assign result.spread      = out_spread_reg;
    assign result.warn        = out_warn_reg;

`ifndef SYNTHESIS
    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the wait state");

    a_no_start_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider restarted while busy");

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        ram_rd_en |-> !ram_wr.en)
        else $error("state RAM read and write in the same cycle");

    a_load_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (state_reg == ST_IDLE) && out_valid_reg)
        else $error("result load did not present a transaction");
`endif

endmodule

`default_nettype wire
